### design/cpe_pkg.sv
// shared types and constants for the column predicate evaluator
`timescale 1ns / 1ps
package cpe_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int PAT_BYTES   = 16;
   localparam int PAT_IDX_W   = 4;
   localparam int PLEN_W      = 5;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int SEEN_W      = 5;
   localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [2:0] REG_PREDICATE_OP  = 3'd0;
   localparam logic [2:0] REG_INT_CONSTANT  = 3'd1;
   localparam logic [2:0] REG_PATTERN_LEN   = 3'd2;
   localparam logic [2:0] REG_PATTERN_LOW   = 3'd3;
   localparam logic [2:0] REG_PATTERN_HIGH  = 3'd4;

   typedef enum logic [4:0] {
      OP_INT_EQ       = 5'd0,
      OP_INT_NE       = 5'd1,
      OP_INT_GT       = 5'd2,
      OP_INT_GE       = 5'd3,
      OP_INT_LT       = 5'd4,
      OP_INT_LE       = 5'd5,
      OP_STR_EQ       = 5'd6,
      OP_STR_NE       = 5'd7,
      OP_STR_GT       = 5'd8,
      OP_STR_GE       = 5'd9,
      OP_STR_LT       = 5'd10,
      OP_STR_LE       = 5'd11,
      OP_STARTS       = 5'd12,
      OP_NOT_STARTS   = 5'd13,
      OP_ENDS         = 5'd14,
      OP_NOT_ENDS     = 5'd15,
      OP_CONTAINS     = 5'd16,
      OP_NOT_CONTAINS = 5'd17
   } op_type;

   typedef enum logic [1:0] {
      ORD_EQ = 2'd0,
      ORD_LT = 2'd1,
      ORD_GT = 2'd2
   } ord_type;

   typedef struct packed {
      logic [4:0]                   op;
      logic signed [63:0]           int_constant;
      logic [LEN_W-1:0]             eff_len;
      logic [PATTERN_MAX-1:0][7:0]  aligned;
      logic [PATTERN_MAX-1:0]       care;
      logic [PAT_BYTES-1:0][7:0]    pattern;
   } cfg_type;

endpackage

### design/cpe_csr.sv
// configuration registers and derived pattern alignment
`timescale 1ns / 1ps
module cpe_csr import cpe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [4:0]                  op_ff;
   logic signed [63:0]          int_constant_ff;
   logic [PLEN_W-1:0]           pattern_length_ff;
   logic [63:0]                 pattern_low_ff;
   logic [63:0]                 pattern_high_ff;
   logic [LEN_W-1:0]            eff_len_ff;
   logic [LEN_W-1:0]            eff_len_in;
   logic [PATTERN_MAX-1:0][7:0] aligned_ff;
   logic [PATTERN_MAX-1:0][7:0] aligned_in;
   logic [PATTERN_MAX-1:0]      care_ff;
   logic [PATTERN_MAX-1:0]      care_in;
   logic [PAT_BYTES-1:0][7:0]   pattern;
   logic [PLEN_W-1:0]           sat_len;
   logic [PLEN_W-1:0]           cut_len;
   logic                        wr;
   logic [2:0]                  index;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign index      = csr_paddr[5:3];
   assign pattern    = {pattern_high_ff, pattern_low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff             <= '0;
         int_constant_ff   <= '0;
         pattern_length_ff <= '0;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
      end else if (wr) begin
         case (index)
            REG_PREDICATE_OP: op_ff             <= csr_pwdata[4:0];
            REG_INT_CONSTANT: int_constant_ff   <= csr_pwdata;
            REG_PATTERN_LEN:  pattern_length_ff <= csr_pwdata[PLEN_W-1:0];
            REG_PATTERN_LOW:  pattern_low_ff    <= csr_pwdata;
            REG_PATTERN_HIGH: pattern_high_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_PREDICATE_OP: csr_prdata = {59'd0, op_ff};
         REG_INT_CONSTANT: csr_prdata = int_constant_ff;
         REG_PATTERN_LEN:  csr_prdata = {{(CSR_DATA_W-PLEN_W){1'b0}}, pattern_length_ff};
         REG_PATTERN_LOW:  csr_prdata = pattern_low_ff;
         REG_PATTERN_HIGH: csr_prdata = pattern_high_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // effective length: saturate, then cut at the first zero pattern byte
   always_comb begin
      sat_len = (pattern_length_ff > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX)
                                                           : pattern_length_ff;
      cut_len = sat_len;
      for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
         if ((PLEN_W'(i) < sat_len) && (pattern[i] == 8'd0)) begin
            cut_len = PLEN_W'(i);
         end
      end
      eff_len_in = cut_len[LEN_W-1:0];
   end

   // window slot k holds the pattern byte that must match there, newest first
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         aligned_in[k] = 8'd0;
         care_in[k]    = (PLEN_W'(k) < cut_len);
         for (int j = 0; j < PATTERN_MAX; j++) begin
            if (PLEN_W'(j + k + 1) == cut_len) begin
               aligned_in[k] = pattern[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_len_ff <= '0;
         aligned_ff <= '0;
         care_ff    <= '0;
      end else begin
         eff_len_ff <= eff_len_in;
         aligned_ff <= aligned_in;
         care_ff    <= care_in;
      end
   end

   assign cfg.op           = op_ff;
   assign cfg.int_constant = int_constant_ff;
   assign cfg.eff_len      = eff_len_ff;
   assign cfg.aligned      = aligned_ff;
   assign cfg.care         = care_ff;
   assign cfg.pattern      = pattern;

endmodule

### design/cpe_int_compare.sv
// signed integer comparison against the configured constant
`timescale 1ns / 1ps
module cpe_int_compare import cpe_pkg::*; (
   input  cfg_type            cfg,
   input  logic signed [63:0] value,
   output logic               int_match
);

   logic eq;
   logic gt;

   assign eq = (value == cfg.int_constant);
   assign gt = (value > cfg.int_constant);

   always_comb begin
      case (cfg.op)
         OP_INT_EQ: int_match = eq;
         OP_INT_NE: int_match = !eq;
         OP_INT_GT: int_match = gt;
         OP_INT_GE: int_match = gt || eq;
         OP_INT_LT: int_match = !(gt || eq);
         OP_INT_LE: int_match = !gt;
         default:   int_match = 1'b0;
      endcase
   end

endmodule

### design/cpe_string_unit.sv
// per-string state and window comparators for the string tests
`timescale 1ns / 1ps
module cpe_string_unit import cpe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       absorb,
   input  logic       finish,
   input  logic [7:0] text_byte,
   output logic       str_match
);

   logic [SEEN_W-1:0]           seen_ff;
   logic [SEEN_W-1:0]           seen_in;
   ord_type                     ord_ff;
   ord_type                     ord_in;
   ord_type                     ord_end;
   logic                        prefix_ff;
   logic                        prefix_in;
   logic                        found_ff;
   logic                        found_in;
   logic [PATTERN_MAX-1:0][7:0] win_ff;
   logic [PATTERN_MAX-1:0][7:0] win_in;
   logic                        in_pat;
   logic [7:0]                  pat_now;
   logic                        tail_hit;
   logic                        tail_end;
   logic                        hit;
   logic                        long_enough;
   logic                        starts;
   logic                        ends;
   logic                        has;

   assign in_pat  = seen_ff < SEEN_W'(cfg.eff_len);
   assign pat_now = cfg.pattern[seen_ff[PAT_IDX_W-1:0]];
   assign seen_in = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + SEEN_W'(1);

   always_comb begin
      win_in[0] = text_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_in[k] = win_ff[k-1];
      end
      tail_hit = 1'b1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (cfg.care[k] && (win_in[k] != cfg.aligned[k])) begin
            tail_hit = 1'b0;
         end
      end
   end

   assign hit      = (seen_in >= SEEN_W'(cfg.eff_len)) && tail_hit;
   assign found_in = found_ff || hit;

   always_comb begin
      ord_in    = ord_ff;
      prefix_in = prefix_ff;
      if (in_pat) begin
         if (text_byte != pat_now) begin
            prefix_in = 1'b0;
            if (ord_ff == ORD_EQ) begin
               ord_in = (text_byte < pat_now) ? ORD_LT : ORD_GT;
            end
         end
      end else if (ord_ff == ORD_EQ) begin
         ord_in = ORD_GT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         seen_ff   <= '0;
         ord_ff    <= ORD_EQ;
         prefix_ff <= 1'b1;
         found_ff  <= 1'b0;
      end else if (absorb) begin
         seen_ff   <= seen_in;
         ord_ff    <= ord_in;
         prefix_ff <= prefix_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (absorb) begin
         win_ff <= win_in;
      end
   end

   // suffix test on the window as it stands when the zero byte arrives
   always_comb begin
      tail_end = 1'b1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (cfg.care[k] && (win_ff[k] != cfg.aligned[k])) begin
            tail_end = 1'b0;
         end
      end
   end

   // answer for the string that the zero byte closes
   assign long_enough = seen_ff >= SEEN_W'(cfg.eff_len);
   assign ord_end     = ((ord_ff == ORD_EQ) && !long_enough) ? ORD_LT : ord_ff;
   assign starts      = prefix_ff && long_enough;
   assign ends        = long_enough && tail_end;
   assign has         = found_ff || (cfg.eff_len == '0);

   always_comb begin
      case (cfg.op)
         OP_STR_EQ:       str_match = (ord_end == ORD_EQ);
         OP_STR_NE:       str_match = (ord_end != ORD_EQ);
         OP_STR_GT:       str_match = (ord_end == ORD_GT);
         OP_STR_GE:       str_match = (ord_end != ORD_LT);
         OP_STR_LT:       str_match = (ord_end == ORD_LT);
         OP_STR_LE:       str_match = (ord_end != ORD_GT);
         OP_STARTS:       str_match = starts;
         OP_NOT_STARTS:   str_match = !starts;
         OP_ENDS:         str_match = ends;
         OP_NOT_ENDS:     str_match = !ends;
         OP_CONTAINS:     str_match = has;
         OP_NOT_CONTAINS: str_match = !has;
         default:         str_match = 1'b0;
      endcase
   end

endmodule

### design/column_predicate_evaluator.sv
// top level: input register, predicate logic and result register
//
// channel   direction  handshake             payload
// req       in         req_valid / req_stall  req_func, req_int_value, req_text_byte
// rsp       out        rsp_valid / rsp_stall  rsp_match
// csr       in         apb write, pready=1    register at byte address 8*index
//
// one item per cycle unless req_stall holds the input; an accepted item passes the input register,
// the predicate logic and then the result register, where its result becomes valid
// non-zero string bytes give no result; the zero byte gives the string's answer
// reset clears the string state and sets every configuration register to zero
// a stalled result holds in the result register while string bytes keep flowing
`timescale 1ns / 1ps
module column_predicate_evaluator import cpe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic signed [63:0]    req_int_value,
   input  logic [7:0]            req_text_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_match,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type            cfg;
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic               s1_func_ff;
   logic signed [63:0] s1_int_ff;
   logic [7:0]         s1_byte_ff;
   logic               s1_has_result;
   logic               s1_advance;
   logic               out_free;
   logic               accept;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_match_ff;
   logic               int_match;
   logic               str_match;
   logic               absorb;
   logic               finish;

   cpe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign s1_has_result = !s1_func_ff || (s1_byte_ff == 8'd0);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign s1_advance    = s1_valid_ff && (!s1_has_result || out_free);
   assign req_stall     = s1_valid_ff && !s1_advance;
   assign accept        = req_valid && !req_stall;

   assign absorb = s1_advance && s1_func_ff && (s1_byte_ff != 8'd0);
   assign finish = s1_advance && s1_func_ff && (s1_byte_ff == 8'd0);

   cpe_int_compare u_int_compare (
      .cfg       (cfg),
      .value     (s1_int_ff),
      .int_match (int_match)
   );

   cpe_string_unit u_string_unit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .absorb    (absorb),
      .finish    (finish),
      .text_byte (s1_byte_ff),
      .str_match (str_match)
   );

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_advance && s1_has_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff <= req_func;
         s1_int_ff  <= req_int_value;
         s1_byte_ff <= req_text_byte;
      end
      if (s1_advance && s1_has_result) begin
         rsp_match_ff <= s1_func_ff ? str_match : int_match;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match = rsp_match_ff;

endmodule

### design/cpe_checker.sv
// port-level checks for the column predicate evaluator, with bind
`timescale 1ns / 1ps
module cpe_checker import cpe_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  req_func,
   input logic signed [63:0]    req_int_value,
   input logic [7:0]            req_text_byte,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_match,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_match)))
      else $error("stalled result changed");

   // input side only backs up behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // an accepted integer item reaches the result register when the output is free
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_func) ##1 !rsp_stall |=> rsp_valid)
      else $error("integer item gave no result");

   // a non-zero string byte gives no result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func && (req_text_byte != 8'd0)) ##1 !rsp_valid
      |=> !rsp_valid)
      else $error("string byte gave a result");

endmodule

bind column_predicate_evaluator cpe_checker u_cpe_checker (.*);

### tb/column_predicate_evaluator_test.sv
// self-checking testbench for the column predicate evaluator
`timescale 1ns / 1ps
module column_predicate_evaluator_test;
   import cpe_pkg::*;

   localparam int RESULT_LATENCY = 2;
   localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_ITEMS   = 600;
   localparam int OP_COUNT       = OP_NOT_CONTAINS + 1;
   localparam logic [4:0] OP_UNUSED_TOP = 5'd31;
   localparam logic signed [63:0] INT_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] INT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef logic [7:0] text_type [$];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_func = 1'b0;
   logic signed [63:0]    req_int_value = '0;
   logic [7:0]            req_text_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_match;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predicate settings as last written
   logic [4:0]         cfg_op = '0;
   logic signed [63:0] cfg_constant = '0;
   logic [4:0]         cfg_pattern_len = '0;
   logic [63:0]        cfg_pattern_low = '0;
   logic [63:0]        cfg_pattern_high = '0;

   // string progress
   logic [SEEN_W-1:0] text_count = '0;
   ord_type           text_order = ORD_EQ;
   logic              head_ok = 1'b1;
   logic              pattern_found = 1'b0;
   logic [7:0]        tail_bytes [PATTERN_MAX] = '{default: 8'd0};

   logic expected_matches [$];
   int   mismatch_count = 0;
   int   cycle_count = 0;
   int   burst_left = 0;
   logic hold_request = 1'b0;
   int   hold_left = 0;
   int   stall_mode = 0;
   int   stall_run = 0;

   column_predicate_evaluator dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** column_predicate_evaluator: FAILED **");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [7:0] pattern_byte(input int i);
      logic [127:0] all;
      all = {cfg_pattern_high, cfg_pattern_low};
      return all[i*8 +: 8];
   endfunction

   function automatic int effective_length();
      int n;
      n = (cfg_pattern_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_pattern_len);
      for (int i = 0; i < n; i++)
         if (pattern_byte(i) == 8'd0) return i;
      return n;
   endfunction

   function automatic logic tail_matches(input int len);
      for (int j = 0; j < len; j++)
         if (tail_bytes[len-1-j] != pattern_byte(j)) return 1'b0;
      return 1'b1;
   endfunction

   // predict the answer, if any, that one accepted item produces
   task automatic judge_item(input logic func, input logic signed [63:0] value,
                             input logic [7:0] text);
      int         len;
      ord_type    ord;
      logic       starts, ends, has, answer;
      logic [7:0] want;
      len = effective_length();
      if (!func) begin
         case (cfg_op)
            OP_INT_EQ: answer = (value == cfg_constant);
            OP_INT_NE: answer = (value != cfg_constant);
            OP_INT_GT: answer = (value > cfg_constant);
            OP_INT_GE: answer = (value >= cfg_constant);
            OP_INT_LT: answer = (value < cfg_constant);
            OP_INT_LE: answer = (value <= cfg_constant);
            default:   answer = 1'b0;
         endcase
         expected_matches.push_back(answer);
      end else if (text != 8'd0) begin
         if (text_count < len) begin
            want = pattern_byte(text_count);
            if (text != want) begin
               head_ok = 1'b0;
               if (text_order == ORD_EQ) text_order = (text < want) ? ORD_LT : ORD_GT;
            end
         end else if (text_order == ORD_EQ) begin
            text_order = ORD_GT;
         end
         for (int k = PATTERN_MAX - 1; k > 0; k--) tail_bytes[k] = tail_bytes[k-1];
         tail_bytes[0] = text;
         if (text_count != SEEN_MAX) text_count++;
         if (text_count >= len && tail_matches(len)) pattern_found = 1'b1;
      end else begin
         ord = text_order;
         starts = head_ok && (text_count >= len);
         ends = (text_count >= len) && tail_matches(len);
         has = pattern_found || (len == 0);
         if (ord == ORD_EQ && text_count < len) ord = ORD_LT;
         case (cfg_op)
            OP_STR_EQ:       answer = (ord == ORD_EQ);
            OP_STR_NE:       answer = (ord != ORD_EQ);
            OP_STR_GT:       answer = (ord == ORD_GT);
            OP_STR_GE:       answer = (ord != ORD_LT);
            OP_STR_LT:       answer = (ord == ORD_LT);
            OP_STR_LE:       answer = (ord != ORD_GT);
            OP_STARTS:       answer = starts;
            OP_NOT_STARTS:   answer = !starts;
            OP_ENDS:         answer = ends;
            OP_NOT_ENDS:     answer = !ends;
            OP_CONTAINS:     answer = has;
            OP_NOT_CONTAINS: answer = !has;
            default:         answer = 1'b0;
         endcase
         expected_matches.push_back(answer);
         text_count = '0;
         text_order = ORD_EQ;
         head_ok = 1'b1;
         pattern_found = 1'b0;
         foreach (tail_bytes[k]) tail_bytes[k] = 8'd0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matches.size() == 0) begin
            report_mismatch("result with no item pending");
         end else begin
            if (rsp_match !== expected_matches[0])
               report_mismatch($sformatf("match %b, predicted %b", rsp_match,
                                         expected_matches[0]));
            void'(expected_matches.pop_front());
         end
      end
   end

   // receiver stall pattern, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run = $urandom_range(5, 60);
         end
         stall_run--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= $urandom_range(0, 1);
         endcase
      end
   end

   task automatic send_item(input logic func, input logic [63:0] value,
                            input logic [7:0] text);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= func;
      req_int_value <= value;
      req_text_byte <= text;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      judge_item(func, value, text);
   endtask

   task automatic send_value(input logic [63:0] value);
      send_item(1'b0, value, 8'($urandom));
   endtask

   // send a string and its terminator, with an integer item optionally slipped in at one place
   task automatic send_text(input text_type s, input int inject_at);
      for (int i = 0; i < s.size(); i++) begin
         if (i == inject_at) send_value(random_word());
         send_item(1'b1, random_word(), s[i]);
      end
      if (inject_at == s.size()) send_value(random_word());
      send_item(1'b1, random_word(), 8'd0);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [63:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_PREDICATE_OP: cfg_op = data[4:0];
         REG_INT_CONSTANT: cfg_constant = data;
         REG_PATTERN_LEN:  cfg_pattern_len = data[4:0];
         REG_PATTERN_LOW:  cfg_pattern_low = data;
         REG_PATTERN_HIGH: cfg_pattern_high = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_predicate(input logic [4:0] op, input logic signed [63:0] constant,
                                input logic [4:0] plen, input logic [127:0] pattern);
      logic [63:0] noise;
      wait_for_results();
      noise = random_word();
      write_register(REG_PREDICATE_OP, {noise[63:5], op});
      write_register(REG_INT_CONSTANT, constant);
      write_register(REG_PATTERN_LEN, {noise[58:0], plen});
      write_register(REG_PATTERN_LOW, pattern[63:0]);
      write_register(REG_PATTERN_HIGH, pattern[127:64]);
   endtask

   function automatic text_type to_text(input string str);
      text_type s;
      for (int i = 0; i < str.len(); i++) s.push_back(str[i]);
      return s;
   endfunction

   function automatic logic [127:0] pack_text(input text_type s);
      logic [127:0] bits;
      bits = '0;
      for (int i = 0; i < s.size() && i < PAT_BYTES; i++) bits[i*8 +: 8] = s[i];
      return bits;
   endfunction

   function automatic logic [7:0] text_char(input text_type pat);
      int r;
      r = $urandom_range(0, 9);
      if (r < 4 && pat.size() != 0) return pat[$urandom_range(0, pat.size() - 1)];
      if (r < 6) return "a";
      return 8'($urandom_range(1, 255));
   endfunction

   // strings built around the pattern so that the random predicate test gets hits and near misses
   function automatic text_type make_text(input text_type pat);
      text_type s;
      int       cut;
      case ($urandom_range(0, 7))
         0: s = pat;
         1: begin
            s = pat;
            repeat ($urandom_range(1, 4)) s.push_back(text_char(pat));
         end
         2: begin
            repeat ($urandom_range(1, 4)) s.push_back(text_char(pat));
            s = {s, pat};
         end
         3: begin
            repeat ($urandom_range(1, 4)) s.push_back(text_char(pat));
            s = {s, pat};
            repeat ($urandom_range(1, 4)) s.push_back(text_char(pat));
         end
         4: begin
            cut = (pat.size() != 0) ? $urandom_range(0, pat.size() - 1) : 0;
            for (int i = 0; i < cut; i++) s.push_back(pat[i]);
         end
         5: begin
            s = pat;
            if (s.size() != 0) s[$urandom_range(0, s.size() - 1)] = text_char(pat);
         end
         6: repeat ($urandom_range(0, 12)) s.push_back(text_char(pat));
         default: repeat ($urandom_range(17, 40)) s.push_back(text_char(pat));
      endcase
      return s;
   endfunction

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return cfg_constant;
         1:       return cfg_constant + 64'sd1;
         2:       return cfg_constant - 64'sd1;
         3:       return INT_MIN;
         4:       return INT_MAX;
         default: return random_word();
      endcase
   endfunction

   task automatic test_integer_extremes();
      set_predicate(OP_INT_EQ, INT_MIN, '0, '0);
      send_value(INT_MIN);
      set_predicate(OP_INT_NE, INT_MAX, '0, '0);
      send_value(INT_MIN);
      set_predicate(OP_INT_GT, INT_MIN, '0, '0);
      send_value(INT_MAX);
      set_predicate(OP_INT_GE, INT_MAX, '0, '0);
      send_value(INT_MAX);
      set_predicate(OP_INT_LT, INT_MAX, '0, '0);
      send_value(-64'sd1);
      set_predicate(OP_INT_LE, INT_MIN, '0, '0);
      send_value(64'd0);
   endtask

   task automatic test_empty_pattern();
      text_type nothing;
      set_predicate(OP_ENDS, '0, '0, pack_text(to_text("xy")));
      send_text(nothing, -1);
      // length five, but the first pattern byte is zero
      set_predicate(OP_NOT_CONTAINS, '0, 5'd5, '0);
      send_text(to_text("a"), -1);
   endtask

   task automatic test_type_mismatch();
      text_type nothing;
      set_predicate(OP_STARTS, '0, 5'd2, pack_text(to_text("ab")));
      send_value(random_word());
      send_text(to_text("ab"), 1);
      set_predicate(OP_INT_EQ, '0, 5'd2, pack_text(to_text("ab")));
      send_text(nothing, -1);
   endtask

   task automatic test_unused_op();
      set_predicate(OP_UNUSED_TOP, '0, 5'd1, pack_text(to_text("a")));
      send_value(64'd0);
      send_text(to_text("a"), -1);
   endtask

   task automatic test_midstring_write();
      set_predicate(OP_STARTS, '0, 5'd2, pack_text(to_text("ab")));
      send_item(1'b1, random_word(), "a");
      send_item(1'b1, random_word(), "b");
      set_predicate(OP_STARTS, '0, 5'd3, pack_text(to_text("abc")));
      send_text(to_text("c"), -1);
   endtask

   task automatic test_long_text();
      text_type s;
      set_predicate(OP_ENDS, '0, OP_UNUSED_TOP, '1);
      repeat (20) s.push_back("a");
      repeat (PATTERN_MAX) s.push_back(8'hFF);
      send_text(s, -1);
   endtask

   task automatic test_backpressure();
      set_predicate(OP_INT_LE, '0, '0, '0);
      hold_request = 1'b1;
      repeat (40) send_value(random_word());
   endtask

   task automatic test_random_predicates();
      int           phase, sent, phase_end, inject;
      logic [4:0]   op;
      logic [63:0]  constant;
      logic [4:0]   plen;
      logic [127:0] pattern;
      logic [7:0]   b;
      text_type     pat, s;
      phase = 0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         op = (phase % 20 < OP_COUNT) ? 5'(phase % 20)
                                      : 5'($urandom_range(OP_COUNT, OP_UNUSED_TOP));
         case ($urandom_range(0, 4))
            0:       constant = INT_MIN;
            1:       constant = INT_MAX;
            default: constant = random_word();
         endcase
         case ($urandom_range(0, 9))
            0:       plen = '0;
            1:       plen = 5'($urandom_range(PATTERN_MAX + 1, 31));
            2:       plen = 5'(PATTERN_MAX);
            default: plen = 5'($urandom_range(1, PATTERN_MAX));
         endcase
         for (int i = 0; i < PAT_BYTES; i++) begin
            b = ($urandom_range(0, 1) == 0) ? 8'("a" + $urandom_range(0, 2))
                                             : 8'($urandom_range(1, 255));
            if ($urandom_range(0, 19) == 0) b = 8'd0;
            pattern[i*8 +: 8] = b;
         end
         set_predicate(op, constant, plen, pattern);
         pat.delete();
         for (int i = 0; i < effective_length(); i++) pat.push_back(pattern_byte(i));
         phase_end = sent + $urandom_range(20, 45);
         while (sent < phase_end) begin
            if ($urandom_range(0, 9) < 3) begin
               send_value(pick_value());
               sent++;
            end else begin
               s = make_text(pat);
               inject = ($urandom_range(0, 9) == 0) ? $urandom_range(0, s.size()) : -1;
               send_text(s, inject);
               sent += s.size() + 1 + (inject >= 0);
            end
         end
         phase++;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_integer_extremes();
      test_empty_pattern();
      test_type_mismatch();
      test_unused_op();
      test_midstring_write();
      test_long_text();
      test_backpressure();
      test_random_predicates();
      wait_for_results();
      if (mismatch_count == 0) begin
         $display("** column_predicate_evaluator: PASSED **");
      end else begin
         $display("** column_predicate_evaluator: FAILED **");
      end
      $finish;
   end

endmodule
